>>> src/fqa_pkg.sv
// Shared types, opcodes and status codes for the Q24.8 fixed-point ALU.
package fqa_pkg;

  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned CmdBits     = 4;
  localparam int unsigned StatBits    = 2;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_GT    = 4'd4,
    CMD_LT    = 4'd5,
    CMD_GE    = 4'd6,
    CMD_LE    = 4'd7,
    CMD_EQ    = 4'd8,
    CMD_NE    = 4'd9,
    CMD_MAX   = 4'd10,
    CMD_MIN   = 4'd11,
    CMD_INC   = 4'd12,
    CMD_DEC   = 4'd13,
    CMD_TOINT = 4'd14
  } cmd_e;

  typedef enum logic [StatBits-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } stat_e;

endpackage

>>> src/fqa_delay.sv
// Enabled payload delay line used to align short paths with the divider.
module fqa_delay #(
  parameter int unsigned LEN   = 1,
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [LEN];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int i = 1; i < LEN; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign data_o = tap_q[LEN-1];

endmodule

>>> src/fqa_mul.sv
// Three-stage signed fixed-point multiplier with rounding and saturation.
module fqa_mul #(
  parameter int unsigned FRAC_BITS = fqa_pkg::FracBitsDef,
  parameter int unsigned WORD_BITS = fqa_pkg::WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [WORD_BITS-1:0] mag_a_i,
  input  logic [WORD_BITS-1:0] mag_b_i,
  input  logic                 neg_i,
  output logic [WORD_BITS-1:0] result_o,
  output fqa_pkg::stat_e       status_o
);
  import fqa_pkg::*;

  localparam int unsigned H = (WORD_BITS + 1) / 2;
  localparam int unsigned P = 4 * H;
  localparam logic [P-1:0] Rnd  = P'(1) << (FRAC_BITS - 1);
  localparam logic [P-1:0] LimN = {{(P-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [P-1:0] LimP = LimN - P'(1);

  logic [2*H-1:0] a_ext, b_ext;
  logic [2*H-1:0] p00_q, p01_q, p10_q, p11_q;
  logic           neg1_q, neg2_q;
  logic [P-1:0]   prod_d, prod_q;
  logic [P-1:0]   rnd, lim, mag;
  logic           ovf;

  assign a_ext = (2*H)'(mag_a_i);
  assign b_ext = (2*H)'(mag_b_i);

  assign prod_d = P'(p00_q) + (P'({1'b0, p01_q} + {1'b0, p10_q}) << H) + (P'(p11_q) << (2*H));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q  <= a_ext[H-1:0] * b_ext[H-1:0];
      p01_q  <= a_ext[H-1:0] * b_ext[2*H-1:H];
      p10_q  <= a_ext[2*H-1:H] * b_ext[H-1:0];
      p11_q  <= a_ext[2*H-1:H] * b_ext[2*H-1:H];
      neg1_q <= neg_i;
      prod_q <= prod_d;
      neg2_q <= neg1_q;
      result_o <= neg2_q ? (WORD_BITS'(0) - mag[WORD_BITS-1:0]) : mag[WORD_BITS-1:0];
      status_o <= ovf ? ST_OVF : ST_OK;
    end
  end

  always_comb begin
    rnd = (prod_q + Rnd) >> FRAC_BITS;
    lim = neg2_q ? LimN : LimP;
    ovf = rnd > lim;
    mag = ovf ? lim : rnd;
  end

endmodule

>>> src/fqa_div.sv
// Pipelined restoring divider, one quotient bit per stage, round and saturate.
module fqa_div #(
  parameter int unsigned FRAC_BITS = fqa_pkg::FracBitsDef,
  parameter int unsigned WORD_BITS = fqa_pkg::WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [WORD_BITS-1:0] mag_a_i,
  input  logic [WORD_BITS-1:0] mag_b_i,
  input  logic                 neg_i,
  output logic [WORD_BITS-1:0] result_o,
  output fqa_pkg::stat_e       status_o
);
  import fqa_pkg::*;

  localparam int unsigned Q = WORD_BITS + FRAC_BITS;
  localparam logic [Q:0] LimN = {{(Q+1-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [Q:0] LimP = LimN - (Q+1)'(1);

  logic [Q-1:0]         nq_q  [Q+1];
  logic [WORD_BITS-1:0] rem_q [Q+1];
  logic [WORD_BITS-1:0] d_q   [Q+1];
  logic                 neg_q [Q+1];
  logic [Q:0]           qr, lim, mag;
  logic                 up, ovf, zero;

  assign nq_q[0]  = {mag_a_i, {FRAC_BITS{1'b0}}};
  assign rem_q[0] = '0;
  assign d_q[0]   = mag_b_i;
  assign neg_q[0] = neg_i;

  for (genvar i = 0; i < Q; i++) begin : g_stage
    logic [WORD_BITS:0] rem2, diff;
    logic               ge;
    assign rem2 = {rem_q[i], nq_q[i][Q-1]};
    assign diff = rem2 - {1'b0, d_q[i]};
    assign ge   = rem2 >= {1'b0, d_q[i]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[i+1]  <= {nq_q[i][Q-2:0], ge};
        rem_q[i+1] <= ge ? diff[WORD_BITS-1:0] : rem2[WORD_BITS-1:0];
        d_q[i+1]   <= d_q[i];
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  always_comb begin
    zero = d_q[Q] == '0;
    up   = rem_q[Q] >= (d_q[Q] - rem_q[Q]);
    qr   = {1'b0, nq_q[Q]} + (Q+1)'(up);
    lim  = neg_q[Q] ? LimN : LimP;
    ovf  = qr > lim;
    mag  = ovf ? lim : qr;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero) begin
        result_o <= '0;
        status_o <= ST_DIVZ;
      end else begin
        result_o <= neg_q[Q] ? (WORD_BITS'(0) - mag[WORD_BITS-1:0]) : mag[WORD_BITS-1:0];
        status_o <= ovf ? ST_OVF : ST_OK;
      end
    end
  end

endmodule

>>> src/fixed_point_q24_8_alu.sv
// Top level of the pipelined Q24.8 fixed-point ALU.
// Input stream: s_axis_tdata_i carries operand_a (low word) and operand_b,
// s_axis_tuser_i carries the opcode. Output stream: m_axis_tdata_o carries
// the result, m_axis_tuser_o the status (ok, overflow, divide by zero).
// Every opcode takes the same path length, so results leave in issue order.
// For Q24.8 as for any width, the pipeline is one input register, one
// divider stage per quotient bit, a round and saturate stage for the
// divider, and the output register. Throughput is one transaction per
// cycle unless the receiver stalls; the divider pipeline sets the depth.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready_o drops; nothing is lost or repeated.
module fixed_point_q24_8_alu #(
  parameter int unsigned FRAC_BITS = fqa_pkg::FracBitsDef,
  parameter int unsigned WORD_BITS = fqa_pkg::WordBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // operand_a, operand_b, zero pad
  input  logic [((2*WORD_BITS+7)/8)*8-1:0]        s_axis_tdata_i,
  // cmd
  input  logic [fqa_pkg::CmdBits-1:0]             s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // result, zero pad
  output logic [((WORD_BITS+7)/8)*8-1:0]          m_axis_tdata_o,
  // status
  output logic [fqa_pkg::StatBits-1:0]            m_axis_tuser_o
);
  import fqa_pkg::*;

  localparam int unsigned Lat  = WORD_BITS + FRAC_BITS + 1;
  localparam int unsigned OutW = ((WORD_BITS+7)/8)*8;
  localparam logic [WORD_BITS-1:0] WMax = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMin = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                  adv;
  logic                  vld_q [Lat+1];
  cmd_e                  cmd_q [Lat+1];
  logic [WORD_BITS-1:0]  a_q, b_q;
  logic [WORD_BITS-1:0]  mag_a, mag_b, sum, dif;
  logic                  neg;
  logic [WORD_BITS-1:0]  s_res;
  stat_e                 s_st;
  logic [WORD_BITS+StatBits-1:0] s_dly;
  logic [WORD_BITS+StatBits-1:0] m_dly;
  logic [WORD_BITS-1:0]  mul_res, div_res;
  stat_e                 mul_st, div_st;
  logic [WORD_BITS-1:0]  res_d, res_q;
  stat_e                 st_d, st_q;
  logic                  out_vld_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Lat; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i <= Lat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_vld_q <= vld_q[Lat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_q[0] <= cmd_e'(s_axis_tuser_i);
      a_q      <= s_axis_tdata_i[WORD_BITS-1:0];
      b_q      <= s_axis_tdata_i[2*WORD_BITS-1:WORD_BITS];
      for (int i = 1; i <= Lat; i++) begin
        cmd_q[i] <= cmd_q[i-1];
      end
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  assign mag_a = a_q[WORD_BITS-1] ? (WORD_BITS'(0) - a_q) : a_q;
  assign mag_b = b_q[WORD_BITS-1] ? (WORD_BITS'(0) - b_q) : b_q;
  assign neg   = a_q[WORD_BITS-1] ^ b_q[WORD_BITS-1];
  assign sum   = a_q + b_q;
  assign dif   = a_q - b_q;

  always_comb begin
    s_res = '0;
    s_st  = ST_OK;
    case (cmd_q[0])
      CMD_ADD: begin
        s_res = sum;
        if (a_q[WORD_BITS-1] == b_q[WORD_BITS-1] && sum[WORD_BITS-1] != a_q[WORD_BITS-1]) begin
          s_res = a_q[WORD_BITS-1] ? WMin : WMax;
          s_st  = ST_OVF;
        end
      end
      CMD_SUB: begin
        s_res = dif;
        if (a_q[WORD_BITS-1] != b_q[WORD_BITS-1] && dif[WORD_BITS-1] != a_q[WORD_BITS-1]) begin
          s_res = a_q[WORD_BITS-1] ? WMin : WMax;
          s_st  = ST_OVF;
        end
      end
      CMD_GT:  s_res = WORD_BITS'($signed(a_q) >  $signed(b_q));
      CMD_LT:  s_res = WORD_BITS'($signed(a_q) <  $signed(b_q));
      CMD_GE:  s_res = WORD_BITS'($signed(a_q) >= $signed(b_q));
      CMD_LE:  s_res = WORD_BITS'($signed(a_q) <= $signed(b_q));
      CMD_EQ:  s_res = WORD_BITS'(a_q == b_q);
      CMD_NE:  s_res = WORD_BITS'(a_q != b_q);
      CMD_MAX: s_res = ($signed(a_q) > $signed(b_q)) ? a_q : b_q;
      CMD_MIN: s_res = ($signed(a_q) < $signed(b_q)) ? a_q : b_q;
      CMD_INC: begin
        s_res = a_q + WORD_BITS'(1);
        if (a_q == WMax) begin
          s_res = WMax;
          s_st  = ST_OVF;
        end
      end
      CMD_DEC: begin
        s_res = a_q - WORD_BITS'(1);
        if (a_q == WMin) begin
          s_res = WMin;
          s_st  = ST_OVF;
        end
      end
      CMD_TOINT: s_res = WORD_BITS'($signed(a_q) >>> FRAC_BITS);
      default: begin
        s_res = '0;
        s_st  = ST_OK;
      end
    endcase
  end

  fqa_delay #(.LEN(Lat), .WIDTH(WORD_BITS+StatBits)) u_s_dly (
    .clk_i  (clk_i),
    .en_i   (adv),
    .data_i ({s_st, s_res}),
    .data_o (s_dly)
  );

  fqa_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul (
    .clk_i    (clk_i),
    .en_i     (adv),
    .mag_a_i  (mag_a),
    .mag_b_i  (mag_b),
    .neg_i    (neg),
    .result_o (mul_res),
    .status_o (mul_st)
  );

  fqa_delay #(.LEN(Lat-3), .WIDTH(WORD_BITS+StatBits)) u_m_dly (
    .clk_i  (clk_i),
    .en_i   (adv),
    .data_i ({mul_st, mul_res}),
    .data_o (m_dly)
  );

  fqa_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
    .clk_i    (clk_i),
    .en_i     (adv),
    .mag_a_i  (mag_a),
    .mag_b_i  (mag_b),
    .neg_i    (neg),
    .result_o (div_res),
    .status_o (div_st)
  );

  always_comb begin
    case (cmd_q[Lat])
      CMD_MUL: begin
        res_d = m_dly[WORD_BITS-1:0];
        st_d  = stat_e'(m_dly[WORD_BITS+StatBits-1:WORD_BITS]);
      end
      CMD_DIV: begin
        res_d = div_res;
        st_d  = div_st;
      end
      default: begin
        res_d = s_dly[WORD_BITS-1:0];
        st_d  = stat_e'(s_dly[WORD_BITS+StatBits-1:WORD_BITS]);
      end
    endcase
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutW'(res_q);
  assign m_axis_tuser_o  = st_q;

  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && st_q == ST_DIVZ |-> res_q == '0)
    else $error("divide by zero result not zero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q[Lat] == $past(vld_q[Lat]) && vld_q[0] == $past(vld_q[0]))
    else $error("pipeline moved during stall");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> st_q == ST_OK || st_q == ST_OVF || st_q == ST_DIVZ)
    else $error("bad status code");

endmodule
